/* hw/rtl/fpe_pkg.sv */
// ----------------------------------------------------------------------------
// fpe_pkg
// Constants and arithmetic helpers for the fixed-point negative exponential.
// ----------------------------------------------------------------------------
package fpe_pkg;

    localparam int unsigned DataWidth   = 32;
    localparam int unsigned IntBitsW    = 5;
    localparam logic [IntBitsW-1:0] IntBitsReset = 5'd5;
    localparam logic [IntBitsW-1:0] IntBitsMax   = 5'd29;

    localparam logic signed [31:0] ConstNegEighth = 32'sd1895147668;
    localparam logic signed [31:0] ConstThird     = 32'sd715827883;
    localparam logic [5:0]         ClampBase      = 6'd36;

    localparam logic signed [31:0] Pow2Table [7] = '{
        32'sd1672461947, 32'sd1302514674, 32'sd790015084, 32'sd290630308,
        32'sd39332535, 32'sd720401, 32'sd242
    };

    // saturating rounding doubling high multiply
    function automatic logic signed [31:0] dbl_high_mul(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        logic signed [63:0] ab;
        logic signed [63:0] s;
        logic signed [63:0] q;
        begin
            ab = a * b;
            if (ab >= 0)
            begin
                s = ab + 64'sd1073741824;
                q = s >>> 31;
            end
            else
            begin
                s = ab - 64'sd1073741823;
                // truncate toward zero
                q = -((-s) >>> 31);
            end
            if (a == 32'sh8000_0000 && b == 32'sh8000_0000)
                dbl_high_mul = 32'sh7fff_ffff;
            else
                dbl_high_mul = q[31:0];
        end
    endfunction

    // shift right, rounding half away from zero
    function automatic logic signed [31:0] rshr(
        input logic signed [31:0] x,
        input logic [1:0]         e
    );
        logic [31:0] mask;
        logic [31:0] rem;
        logic [31:0] thr;
        logic [31:0] sh;
        begin
            mask = (32'd1 << e) - 32'd1;
            rem  = x & mask;
            thr  = (mask >> 1) + {31'd0, x[31]};
            sh   = x[31] ? ~((~x) >> e) : (x >> e);
            rshr = sh + {31'd0, (rem > thr)};
        end
    endfunction

endpackage

/* hw/rtl/fpe_poly.sv */
// ----------------------------------------------------------------------------
// fpe_poly
// Pipelined exp(f) for f in [-1/4, 0), Q0.31, six register stages.
// ----------------------------------------------------------------------------
module fpe_poly (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic signed [31:0] f,
    output logic signed [31:0] result
);

    logic signed [31:0] x1_reg, x2_reg, x1b_reg, x3_reg, x4_reg, xa_reg, x2b_reg;
    logic signed [31:0] xb_reg, pm_reg, x2c_reg, xc_reg, poly_reg, res_reg;
    logic signed [31:0] x_next;
    logic signed [31:0] pm_next;
    logic signed [31:0] poly_next;
    logic signed [32:0] r_next;
    logic signed [31:0] res_next;

    assign x_next  = f + 32'sd268435456;
    assign pm_next = fpe_pkg::dbl_high_mul(fpe_pkg::rshr(x4_reg, 2'd2) + x3_reg,
                                           fpe_pkg::ConstThird);
    assign poly_next = fpe_pkg::rshr(pm_reg + x2c_reg, 2'd1);
    assign r_next = 33'(fpe_pkg::ConstNegEighth)
        + 33'(fpe_pkg::dbl_high_mul(fpe_pkg::ConstNegEighth, xc_reg + poly_reg));
    assign res_next = (r_next > 33'sh0_7fff_ffff) ? 32'sh7fff_ffff : r_next[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
        end
        else if (en)
        begin
            x1_reg <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 2: x^2
            x2_reg  <= fpe_pkg::dbl_high_mul(x1_reg, x1_reg);
            x1b_reg <= x1_reg;
            // stage 3: x^3, x^4
            x3_reg  <= fpe_pkg::dbl_high_mul(x2_reg, x1b_reg);
            x4_reg  <= fpe_pkg::dbl_high_mul(x2_reg, x2_reg);
            xa_reg  <= x1b_reg;
            x2b_reg <= x2_reg;
            // stage 4
            pm_reg  <= pm_next;
            x2c_reg <= x2b_reg;
            xb_reg  <= xa_reg;
            // stage 5
            poly_reg <= poly_next;
            xc_reg   <= xb_reg;
            // stage 6
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

/* hw/rtl/fixed_point_exp_negative.sv */
// ----------------------------------------------------------------------------
// fixed_point_exp_negative
// exp of a non-positive fixed-point value, Q0.31 result.
// One request per cycle while not stalled; the whole pipe advances when the
// output is not stalled (or its last slot is empty).
// Reset clears valid bits and sets int_bits to 5.
// ----------------------------------------------------------------------------
module fixed_point_exp_negative (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] exp_value
);

    localparam int unsigned PolyLat = 6;
    localparam int unsigned Lat     = PolyLat + 8;

    logic [4:0] ib_reg;
    logic [4:0] ib;
    logic [Lat-1:0] v_reg;
    logic en;

    assign en       = !v_reg[Lat-1] || !out_stall;
    assign in_stall = !en;
    assign out_valid = v_reg[Lat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_reg <= fpe_pkg::IntBitsReset;
            v_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                ib_reg <= cfg_wdata;
            if (en)
                v_reg <= {v_reg[Lat-2:0], in_valid};
        end
    end

    assign ib = (ib_reg > fpe_pkg::IntBitsMax) ? fpe_pkg::IntBitsMax : ib_reg;

    // front end: split into scaled fraction, remainder and flags
    logic [31:0] quarter;
    logic [31:0] part;
    logic signed [31:0] scaled;
    logic [31:0] remainder;
    logic [6:0]  bits_next;
    logic        clamp_next;
    logic [31:0] clampv;

    always_comb
    begin
        quarter   = 32'd1 << (5'd29 - ib);
        part      = (value_in & (quarter - 32'd1)) - quarter;
        scaled    = part << ib;
        remainder = part - value_in;
        for (int k = 0; k < 7; k++)
        begin
            if ({1'b0, ib} + 6'd2 > 6'(k))
                bits_next[k] = remainder[5'(6'd29 - {1'b0, ib} + 6'(k))];
            else
                bits_next[k] = 1'b0;
        end
        clampv     = 32'd0 - (32'd1 << (fpe_pkg::ClampBase - {1'b0, ib}));
        clamp_next = (ib > 5'd5) && ($signed(value_in) < $signed(clampv));
    end

    logic signed [31:0] f_reg;
    logic [6:0] bits_reg [PolyLat+1];
    logic zero_reg [PolyLat+1];
    logic clamp_reg [PolyLat+1];
    logic signed [31:0] pres;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg        <= scaled;
            bits_reg[0]  <= bits_next;
            zero_reg[0]  <= (value_in == 32'd0);
            clamp_reg[0] <= clamp_next;
            for (int i = 1; i <= PolyLat; i++)
            begin
                bits_reg[i]  <= bits_reg[i-1];
                zero_reg[i]  <= zero_reg[i-1];
                clamp_reg[i] <= clamp_reg[i-1];
            end
        end
    end

    fpe_poly u_poly (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .f      (f_reg),
        .result (pres)
    );

    // seven multiply stages, one table constant each
    logic signed [31:0] acc_reg [7];
    logic [6:0] mb_reg [7];
    logic mz_reg [7];
    logic mc_reg [7];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0] <= bits_reg[PolyLat][0]
                ? fpe_pkg::dbl_high_mul(pres, fpe_pkg::Pow2Table[0]) : pres;
            mb_reg[0] <= bits_reg[PolyLat];
            mz_reg[0] <= zero_reg[PolyLat];
            mc_reg[0] <= clamp_reg[PolyLat];
            for (int k = 1; k < 7; k++)
            begin
                acc_reg[k] <= mb_reg[k-1][k]
                    ? fpe_pkg::dbl_high_mul(acc_reg[k-1], fpe_pkg::Pow2Table[k])
                    : acc_reg[k-1];
                mb_reg[k] <= mb_reg[k-1];
                mz_reg[k] <= mz_reg[k-1];
                mc_reg[k] <= mc_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (mz_reg[6])
            exp_value = 31'h7fff_ffff;
        else if (mc_reg[6])
            exp_value = '0;
        else
            exp_value = acc_reg[6][30:0];
    end

endmodule
